/* src/mbps_pkg.sv */
package mbps_pkg;

  localparam int PATTERN_BYTES = 16;
  localparam int LEN_W         = 5;
  localparam int POS_W         = 32;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int MASK_W        = 16;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_OFFSET   = 3'd4;

  typedef struct packed {
    logic [7:0] pattern_byte;
    logic       care;
  } pat_sel_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_offset;
  } result_t;

  // Pattern byte and care bit that window slot idx must meet for a pattern of
  // len bytes; the newest byte (slot 0) lines up with pattern byte len-1.
  function automatic pat_sel_t pat_select(input logic [127:0] pattern,
                                          input logic [MASK_W-1:0] mask,
                                          input logic [LEN_W-1:0] len,
                                          input int idx);
    pat_sel_t   sel;
    logic [3:0] k;
    sel = '0;
    k   = 4'(len - LEN_W'(idx) - LEN_W'(1));
    if (LEN_W'(idx) < len) begin
      sel.pattern_byte = pattern[k*8 +: 8];
      sel.care         = mask[k];
    end
    return sel;
  endfunction

endpackage

/* src/mbps_byte_if.sv */
interface mbps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* src/mbps_result_if.sv */
interface mbps_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

/* src/masked_byte_pattern_scan.sv */
// Masked byte signature search. The image streams in one byte word per clock
// and each byte enters a row of sixteen cells that shift the window and
// compare every slot against its pattern byte in parallel, so a byte is taken
// every cycle with no gaps between scans. Each scan yields one result word:
// the first start position at or after start_offset whose cared-for bytes all
// match, or not-found on the last byte. Results go through a two-word output
// queue; input stalls only while that queue is full. Write the configuration
// registers only while no scan is in progress.
module masked_byte_pattern_scan import mbps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  mbps_byte_if.sink              image,
  mbps_result_if.source          result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [63:0]       pattern_low;
  logic [63:0]       pattern_high;
  logic [MASK_W-1:0] care_mask;
  logic [LEN_W-1:0]  pattern_length;
  logic [POS_W-1:0]  start_offset;

  logic [POS_W-1:0]  position;
  logic              scan_done;

  logic [LEN_W-1:0]  len_eff;
  logic [7:0]        link [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] hit;
  logic              accept;
  logic              fifo_full;
  logic [POS_W:0]    pos_plus;
  logic [POS_W:0]    len_wide;
  logic [POS_W-1:0]  start_pos;
  logic              match;
  logic              push;
  result_t           push_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= MASK_W'(1);
      pattern_length <= LEN_W'(1);
      start_offset   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_CARE_MASK:      care_mask      <= cfg_data[MASK_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_START_OFFSET:   start_offset   <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff = (pattern_length > LEN_W'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES)
                                                            : pattern_length;

  assign image.ready = !fifo_full;
  assign accept      = image.valid && image.ready;

  assign link[0] = image.data_byte;

  for (genvar i = 0; i < PATTERN_BYTES; i++) begin : g_cell
    if (i < PATTERN_BYTES - 1) begin : g_mid
      mbps_cell u_cell (
        .clk     (clk),
        .advance (accept),
        .din     (link[i]),
        .sel     (pat_select({pattern_high, pattern_low}, care_mask, len_eff, i)),
        .dout    (link[i+1]),
        .hit     (hit[i])
      );
    end else begin : g_tail
      mbps_cell u_cell (
        .clk     (clk),
        .advance (accept),
        .din     (link[i]),
        .sel     (pat_select({pattern_high, pattern_low}, care_mask, len_eff, i)),
        .dout    (),
        .hit     (hit[i])
      );
    end
  end

  assign pos_plus  = {1'b0, position} + (POS_W+1)'(1);
  assign len_wide  = (POS_W+1)'(len_eff);
  assign start_pos = POS_W'(pos_plus - len_wide);

  // Test a start only once all its bytes are in and the counter has not topped out
  assign match = !scan_done && (position != POS_MAX) && (len_eff != '0) && care_mask[0]
               && (pos_plus >= len_wide) && (start_pos >= start_offset) && (&hit);

  assign push = accept && (match || (image.last_byte && !scan_done));
  assign push_word.found        = match;
  assign push_word.match_offset = match ? start_pos : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      scan_done <= 1'b0;
    end else if (accept) begin
      if (image.last_byte) begin
        position  <= '0;
        scan_done <= 1'b0;
      end else begin
        if (position != POS_MAX) position <= pos_plus[POS_W-1:0];
        if (match) scan_done <= 1'b1;
      end
    end
  end

  mbps_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (fifo_full),
    .result    (result)
  );

endmodule

/* src/mbps_cell.sv */
module mbps_cell import mbps_pkg::*; (
  input  logic       clk,
  input  logic       advance,
  input  logic [7:0] din,
  input  pat_sel_t   sel,
  output logic [7:0] dout,
  output logic       hit
);

  // Compare the byte entering this slot; it is what the slot holds after the shift
  assign hit = !sel.care || (din == sel.pattern_byte);

  always_ff @(posedge clk) begin
    if (advance) begin
      dout <= din;
    end
  end

endmodule

/* src/mbps_out_fifo.sv */
module mbps_out_fifo import mbps_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  result_t       push_word,
  output logic          full,
  mbps_result_if.source result
);

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop          = result.valid && result.ready;
  assign full         = (count == 2'd2);
  assign result.valid = (count != 2'd0);
  assign result.found        = slots[rd_ptr].found;
  assign result.match_offset = slots[rd_ptr].match_offset;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  import mbps_pkg::*;

  localparam logic [7:0] SIG_BYTE = 8'h78;    // 'x'
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 700;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_TOP = {CFG_INDEX_W{1'b1}};

  class scan_scoreboard;
    logic [63:0]       pat_lo;
    logic [63:0]       pat_hi;
    logic [MASK_W-1:0] care;
    logic [LEN_W-1:0]  plen;
    logic [POS_W-1:0]  first_start;
    logic [7:0]        window [PATTERN_BYTES];
    logic [POS_W-1:0]  position;
    bit                matched;
    result_t           expected_q [$];
    int                errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      pat_lo      = '0;
      pat_hi      = '0;
      care        = MASK_W'(1);
      plen        = LEN_W'(1);
      first_start = '0;
      foreach (window[i]) window[i] = '0;
      position    = '0;
      matched     = 0;
      expected_q.delete();
    endfunction

    function void set_reg(input logic [CFG_INDEX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] val);
      unique case (idx)
        REG_PATTERN_LOW:    pat_lo = val;
        REG_PATTERN_HIGH:   pat_hi = val;
        REG_CARE_MASK:      care = val[MASK_W-1:0];
        REG_PATTERN_LENGTH: plen = val[LEN_W-1:0];
        REG_START_OFFSET:   first_start = val[POS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] pattern_byte(input int k);
      logic [127:0] pat;
      pat = {pat_hi, pat_lo};
      return pat[k*8 +: 8];
    endfunction

    // Lengths past the window clamp to the window size
    function int span();
      return (plen > PATTERN_BYTES) ? PATTERN_BYTES : int'(plen);
    endfunction

    function void note_byte(input logic [7:0] b, input logic last);
      int          len;
      logic [32:0] start;
      bit          ok;
      result_t     r;
      len = span();
      for (int i = PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (!matched && position != POS_MAX && len != 0 && care[0] &&
          {1'b0, position} + 33'd1 >= 33'(len)) begin
        start = {1'b0, position} + 33'd1 - 33'(len);
        if (start[POS_W-1:0] >= first_start) begin
          ok = 1;
          for (int k = 0; k < len; k++)
            if (care[k] && pattern_byte(k) != window[len-1-k]) ok = 0;
          if (ok) begin
            r.found        = 1'b1;
            r.match_offset = start[POS_W-1:0];
            expected_q.push_back(r);
            matched = 1;
          end
        end
      end
      if (position != POS_MAX) position = position + POS_W'(1);
      if (last) begin
        // a scan that never matched reports not-found on its last byte
        if (!matched) begin
          r = '0;
          expected_q.push_back(r);
        end
        position = '0;
        matched  = 0;
      end
    endfunction

    function void check_result(input logic found, input logic [POS_W-1:0] off);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result word with nothing pending: found=%0b match_offset=%0d", found, off);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (found !== exp_r.found) begin
        $error("found: expected %0b, got %0b", exp_r.found, found);
        errors++;
      end
      if (off !== exp_r.match_offset) begin
        $error("match_offset: expected %0d, got %0d", exp_r.match_offset, off);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int unsigned            cycle_count = 0;
  int                     bytes_sent = 0;
  bit                     steady = 0;
  logic [7:0]             img [$];
  scan_scoreboard         sb = new();

  mbps_byte_if   image ();
  mbps_result_if result ();

  masked_byte_pattern_scan u_top (
    .clk       (clk),
    .rst       (rst),
    .image     (image),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready) sb.check_result(result.found, result.match_offset);
      if (image.valid && image.ready) sb.note_byte(image.data_byte, image.last_byte);
    end
  end

  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: stall in random bursts
  initial begin
    int gap;
    result.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = idle_gap();
      if (gap > 0) begin
        result.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Valid stays high from one word to the next unless a gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      image.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    image.valid     <= 1'b1;
    image.data_byte <= b;
    image.last_byte <= last;
    do @(posedge clk); while (!image.ready);
    bytes_sent++;
  endtask

  task automatic send_image();
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
  endtask

  // Hold the input until every pending result is out, then let the block settle
  task automatic settle();
    image.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_pattern_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return {8{SIG_BYTE}};
    return {$urandom, $urandom};
  endfunction

  task automatic pick_settings(input bit all);
    int r;
    if (all || $urandom_range(0, 9) < 6) write_reg(REG_PATTERN_LOW, pick_pattern_word());
    if (all || $urandom_range(0, 9) < 6) write_reg(REG_PATTERN_HIGH, pick_pattern_word());
    if (all || $urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 19);
      if (r < 3) write_reg(REG_CARE_MASK, 64'hFFFF);
      else if (r < 5) write_reg(REG_CARE_MASK, 64'($urandom) & 64'hFFFE);
      else if (r == 5) write_reg(REG_CARE_MASK, '0);
      else write_reg(REG_CARE_MASK, 64'($urandom) | 64'd1);
    end
    if (all || $urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 19);
      if (r == 0) write_reg(REG_PATTERN_LENGTH, '0);
      else if (r < 3) write_reg(REG_PATTERN_LENGTH, 64'(PATTERN_BYTES));
      else if (r == 3) write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(17, 31)));
      else write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(1, 6)));
    end
    if (all || $urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 19);
      if (r < 12) write_reg(REG_START_OFFSET, '0);
      else if (r < 17) write_reg(REG_START_OFFSET, 64'($urandom_range(1, 12)));
      else if (r < 19) write_reg(REG_START_OFFSET, 64'(POS_MAX));
      else write_reg(REG_START_OFFSET, 64'($urandom));
    end
    if ($urandom_range(0, 9) == 0)
      write_reg(CFG_INDEX_W'($urandom_range(REG_START_OFFSET + 1, REG_INDEX_TOP)),
                {$urandom, $urandom});
  endtask

  // Random fill biased toward pattern bytes; usually plant the pattern somewhere
  task automatic random_scan();
    int n;
    int len;
    int at;
    n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 48);
    img.delete();
    for (int i = 0; i < n; i++)
      img.push_back(($urandom_range(0, 99) < 40) ? sb.pattern_byte($urandom_range(0, 15))
                                                 : 8'($urandom));
    len = sb.span();
    if ($urandom_range(0, 3) != 0 && len > 0 && n >= len) begin
      at = $urandom_range(0, n - len);
      for (int k = 0; k < len; k++)
        if (sb.care[k]) img[at+k] = sb.pattern_byte(k);
    end
    send_image();
  endtask

  initial begin
    bit first;
    image.valid     <= 1'b0;
    image.data_byte <= '0;
    image.last_byte <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    rst             <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: single cared-for zero byte
    img = '{8'h00};
    send_image();
    img = '{8'hFF, 8'h00};
    send_image();
    img = '{8'hFF};
    send_image();
    settle();
    write_reg(REG_INDEX_TOP, '1);

    // Four-byte signature with a don't-care third byte
    write_reg(REG_PATTERN_LOW, {32'h0, SIG_BYTE, 8'h55, 8'hAA, SIG_BYTE});
    write_reg(REG_CARE_MASK, 64'h000B);
    write_reg(REG_PATTERN_LENGTH, 64'd4);
    img = '{8'h01, SIG_BYTE, 8'hAA, 8'h00, SIG_BYTE, 8'h02};
    send_image();
    img = '{SIG_BYTE, 8'hAA, 8'h11, SIG_BYTE};
    send_image();
    settle();
    write_reg(REG_START_OFFSET, 64'd2);
    img = '{SIG_BYTE, 8'hAA, 8'h00, SIG_BYTE, SIG_BYTE, 8'hAA, 8'h33, SIG_BYTE};
    send_image();
    settle();
    // Empty pattern, then don't-care first byte
    write_reg(REG_PATTERN_LENGTH, '0);
    write_reg(REG_START_OFFSET, '0);
    img = '{SIG_BYTE};
    send_image();
    settle();
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    write_reg(REG_CARE_MASK, 64'hFFFE);
    send_image();
    settle();

    first = 1;
    while (bytes_sent < RANDOM_BYTES + 24) begin
      steady = ($urandom_range(0, 5) == 0);
      pick_settings(first);
      first = 0;
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 9) == 0) settle();
        random_scan();
      end
      settle();
    end
    steady = 0;
    settle();

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
src/mbps_pkg.sv
src/mbps_byte_if.sv
src/mbps_result_if.sv
src/mbps_cell.sv
src/mbps_out_fifo.sv
src/masked_byte_pattern_scan.sv
tb/tb.sv
